FILE: design/irn_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package irn_pkg;

    localparam int NUMBER_W = 12;
    localparam int SYMBOL_W = 7;
    localparam int PAIR_COUNT = 13;
    localparam int PAIR_IDX_W = 4;

    localparam logic [NUMBER_W-1:0] MAX_CONVERTIBLE = 12'd3999;

    typedef logic [1:0] kind_t;
    localparam kind_t KIND_ROMAN = 2'd0;
    localparam kind_t KIND_ZERO  = 2'd1;
    localparam kind_t KIND_ERROR = 2'd2;

    typedef struct packed {
        kind_t                kind;
        logic [NUMBER_W-1:0]  number;
    } item_t;

    localparam logic [SYMBOL_W-1:0] SYM_NONE = 7'd0;
    localparam logic [SYMBOL_W-1:0] SYM_M = 7'h4D;
    localparam logic [SYMBOL_W-1:0] SYM_D = 7'h44;
    localparam logic [SYMBOL_W-1:0] SYM_C = 7'h43;
    localparam logic [SYMBOL_W-1:0] SYM_L = 7'h4C;
    localparam logic [SYMBOL_W-1:0] SYM_X = 7'h58;
    localparam logic [SYMBOL_W-1:0] SYM_V = 7'h56;
    localparam logic [SYMBOL_W-1:0] SYM_I = 7'h49;

    localparam logic [NUMBER_W-1:0] PAIR_VALUE [PAIR_COUNT] = '{
        12'd1000, 12'd900, 12'd500, 12'd400, 12'd100, 12'd90, 12'd50,
        12'd40, 12'd10, 12'd9, 12'd5, 12'd4, 12'd1
    };

    localparam logic [SYMBOL_W-1:0] PAIR_FIRST [PAIR_COUNT] = '{
        SYM_M, SYM_C, SYM_D, SYM_C, SYM_C, SYM_X, SYM_L,
        SYM_X, SYM_X, SYM_I, SYM_V, SYM_I, SYM_I
    };

    localparam logic [SYMBOL_W-1:0] PAIR_SECOND [PAIR_COUNT] = '{
        SYM_NONE, SYM_M, SYM_NONE, SYM_D, SYM_NONE, SYM_C, SYM_NONE,
        SYM_L, SYM_NONE, SYM_X, SYM_NONE, SYM_V, SYM_NONE
    };

endpackage

`default_nettype wire

FILE: design/irn_front.sv
`timescale 1ns / 1ps
`default_nettype none

module irn_front
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [irn_pkg::NUMBER_W-1:0]      number,
    input  wire logic                              queue_full,
    output logic                                   push,
    output irn_pkg::item_t                         push_item
);

    logic           valid_reg;
    logic           valid_next;
    irn_pkg::item_t item_reg;
    irn_pkg::item_t item_next;
    logic           accept;

    assign push      = valid_reg && !queue_full;
    assign busy      = valid_reg && queue_full;
    assign accept    = start && !busy;
    assign push_item = item_reg;

    always_comb
    begin
        valid_next = accept || (valid_reg && !push);
        item_next  = item_reg;
        if (accept)
        begin
            item_next.number = number;
            if (number > irn_pkg::MAX_CONVERTIBLE)
            begin
                item_next.kind = irn_pkg::KIND_ERROR;
            end
            else if (number == '0)
            begin
                item_next.kind = irn_pkg::KIND_ZERO;
            end
            else
            begin
                item_next.kind = irn_pkg::KIND_ROMAN;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

endmodule

`default_nettype wire

FILE: design/irn_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module irn_queue
#(
    parameter int DEPTH = 2
)
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire irn_pkg::item_t  push_item,
    output logic                 full,
    input  wire logic            pop,
    output logic                 not_empty,
    output irn_pkg::item_t       pop_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    irn_pkg::item_t    mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign pop_item  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

FILE: design/irn_back.sv
`timescale 1ns / 1ps
`default_nettype none

module irn_back
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              queue_not_empty,
    input  wire irn_pkg::item_t                    queue_item,
    output logic                                   pop,
    output logic                                   strobe,
    output logic [irn_pkg::SYMBOL_W-1:0]           symbol,
    output logic                                   last,
    output logic                                   error
);

    logic                               active_reg;
    logic                               active_next;
    irn_pkg::kind_t                     kind_reg;
    irn_pkg::kind_t                     kind_next;
    logic [irn_pkg::NUMBER_W-1:0]       rest_reg;
    logic [irn_pkg::NUMBER_W-1:0]       rest_next;
    logic                               pend_valid_reg;
    logic                               pend_valid_next;
    logic [irn_pkg::SYMBOL_W-1:0]       pend_sym_reg;
    logic [irn_pkg::SYMBOL_W-1:0]       pend_sym_next;
    logic                               strobe_reg;
    logic                               strobe_next;
    logic [irn_pkg::SYMBOL_W-1:0]       symbol_reg;
    logic [irn_pkg::SYMBOL_W-1:0]       symbol_next;
    logic                               last_reg;
    logic                               last_next;
    logic                               error_reg;
    logic                               error_next;
    logic [irn_pkg::PAIR_IDX_W-1:0]     sel;
    logic [irn_pkg::NUMBER_W-1:0]       rest_less;
    logic                               done_now;

    // The largest step value that still fits in what remains of the number.
    always_comb
    begin
        sel = irn_pkg::PAIR_IDX_W'(irn_pkg::PAIR_COUNT - 1);
        for (int i = irn_pkg::PAIR_COUNT - 1; i >= 0; i--)
        begin
            if (rest_reg >= irn_pkg::PAIR_VALUE[i])
            begin
                sel = irn_pkg::PAIR_IDX_W'(i);
            end
        end
    end

    assign rest_less = rest_reg - irn_pkg::PAIR_VALUE[sel];

    always_comb
    begin
        done_now = 1'b0;
        if (active_reg)
        begin
            if (kind_reg != irn_pkg::KIND_ROMAN)
            begin
                done_now = 1'b1;
            end
            else if (pend_valid_reg)
            begin
                done_now = (rest_reg == '0);
            end
            else if (irn_pkg::PAIR_SECOND[sel] == irn_pkg::SYM_NONE)
            begin
                done_now = (rest_less == '0);
            end
        end
    end

    always_comb
    begin
        active_next     = active_reg;
        kind_next       = kind_reg;
        rest_next       = rest_reg;
        pend_valid_next = pend_valid_reg;
        pend_sym_next   = pend_sym_reg;
        strobe_next     = 1'b0;
        symbol_next     = symbol_reg;
        last_next       = last_reg;
        error_next      = error_reg;

        if (active_reg)
        begin
            strobe_next = 1'b1;
            error_next  = 1'b0;
            if (kind_reg != irn_pkg::KIND_ROMAN)
            begin
                symbol_next = irn_pkg::SYM_NONE;
                last_next   = 1'b1;
                error_next  = (kind_reg == irn_pkg::KIND_ERROR);
            end
            else if (pend_valid_reg)
            begin
                symbol_next     = pend_sym_reg;
                pend_valid_next = 1'b0;
                last_next       = (rest_reg == '0);
            end
            else
            begin
                symbol_next = irn_pkg::PAIR_FIRST[sel];
                rest_next   = rest_less;
                if (irn_pkg::PAIR_SECOND[sel] != irn_pkg::SYM_NONE)
                begin
                    pend_valid_next = 1'b1;
                    pend_sym_next   = irn_pkg::PAIR_SECOND[sel];
                    last_next       = 1'b0;
                end
                else
                begin
                    last_next = (rest_less == '0);
                end
            end
        end

        if (done_now)
        begin
            active_next = 1'b0;
        end
        if (pop)
        begin
            active_next     = 1'b1;
            kind_next       = queue_item.kind;
            rest_next       = queue_item.number;
            pend_valid_next = 1'b0;
        end
    end

    assign pop    = queue_not_empty && (!active_reg || done_now);
    assign strobe = strobe_reg;
    assign symbol = symbol_reg;
    assign last   = last_reg;
    assign error  = error_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= 1'b0;
            pend_valid_reg <= 1'b0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            active_reg     <= active_next;
            pend_valid_reg <= pend_valid_next;
            strobe_reg     <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        rest_reg     <= rest_next;
        pend_sym_reg <= pend_sym_next;
        symbol_reg   <= symbol_next;
        last_reg     <= last_next;
        error_reg    <= error_next;
    end

endmodule

`default_nettype wire

FILE: design/integer_to_roman_numeral_unit.sv
// Integer to Roman numeral unit.
// Input channel: drive number and raise start; the transfer happens at a rising
// edge where start is high and busy is low. Busy rises only while the front
// register holds a number and the queue behind it is full.
// Output channel: one character per cycle, each marked by strobe for exactly
// one cycle, with last high on the final character of a number. Zero gives
// one result with symbol 0; a number above 3999 gives one result with symbol 0
// and error high. The receiver cannot stall, so results are never held back.
// When the unit is empty, the first character of a number passes from the front
// register through the queue and the serializer state to the output registers.
// Throughput: the back-end serializer emits one character per cycle and stays
// busy with a number for the length of its numeral, 1 to 15 characters; a queue of
// QUEUE_DEPTH entries lets new numbers enter while the serializer works.
// Reset (rst_n low, asynchronous) empties the front register, the queue and the
// serializer and drops strobe; nothing in flight survives.
`timescale 1ns / 1ps
`default_nettype none

module integer_to_roman_numeral_unit
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [irn_pkg::NUMBER_W-1:0]      number,
    output logic                                   strobe,
    output logic [irn_pkg::SYMBOL_W-1:0]           symbol,
    output logic                                   last,
    output logic                                   error
);

    logic           queue_full;
    logic           queue_not_empty;
    logic           push;
    logic           pop;
    irn_pkg::item_t push_item;
    irn_pkg::item_t pop_item;

    irn_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .number     (number),
        .queue_full (queue_full),
        .push       (push),
        .push_item  (push_item)
    );

    irn_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (queue_full),
        .pop       (pop),
        .not_empty (queue_not_empty),
        .pop_item  (pop_item)
    );

    irn_back u_back
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .queue_not_empty (queue_not_empty),
        .queue_item      (pop_item),
        .pop             (pop),
        .strobe          (strobe),
        .symbol          (symbol),
        .last            (last),
        .error           (error)
    );

endmodule

`default_nettype wire
